// ----- rtl/tfp_pkg.sv -----
// Shared types, constants and helper functions for the tricolor frame buffer painter.
// No dependencies; every other file of the block except tfp_ram imports this package.
package tfp_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int PLANE_DEPTH = (MAX_WIDTH / 8) * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(PLANE_DEPTH);
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int DIM_W       = 10;               // pixel extents, rectangle sizes, config data
  localparam int EXT_W       = DIM_W + 1;        // position plus size
  localparam int POS_W       = 9;
  localparam int BPR_W       = DIM_W - 3;        // bytes per row, up to MAX_WIDTH/8
  localparam int COL_W       = $clog2(MAX_WIDTH / 8);
  localparam int CMD_W       = 2;
  localparam int COLOR_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = DIM_W;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(400);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(300);

  localparam logic [7:0] BYTE_FULL  = 8'hFF;
  localparam logic [7:0] BYTE_EMPTY = 8'h00;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_POINT = 2'd0,
    CMD_RECT  = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_ROTATION = 2'd2,
    CFG_MIRROR   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_BYTE,
    ST_MODIFY,
    ST_FILL,
    ST_RDWAIT
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0]  wd;
    logic [DIM_W-1:0]  ht;
    logic [BPR_W-1:0]  bpr;
    logic [SIZE_W-1:0] size;
    logic [DIM_W-1:0]  xend;
    logic [DIM_W-1:0]  yend;
    logic [1:0]        rotation;
    logic              mirror;
  } geom_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_black;
    logic [7:0]        wr_red;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  // Pixels of one byte covered by a span; MSB is the leftmost pixel
  function automatic logic [7:0] span_mask(input logic is_first, input logic is_last,
                                           input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] lm;
    logic [7:0] rm;
    lm = is_first ? (BYTE_FULL >> lo) : BYTE_FULL;
    rm = is_last ? (BYTE_FULL << (3'd7 - hi)) : BYTE_FULL;
    return lm & rm;
  endfunction

  function automatic logic [7:0] paint(input logic [7:0] old, input logic [7:0] m,
                                       input logic set);
    return (old & ~m) | (set ? m : BYTE_EMPTY);
  endfunction

endpackage

// ----- rtl/tfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module tfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tfp_cfg.sv -----
// Configuration registers and the effective panel geometry derived from them.
// Depends on tfp_pkg.
module tfp_cfg
  import tfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  output geom_t                geom
);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [1:0]       rotation_r;
  logic             mirror_r;
  logic [DIM_W-1:0] width_rnd;
  logic [DIM_W-1:0] wd;
  logic [DIM_W-1:0] ht;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RESET_WIDTH;
      height_r   <= RESET_HEIGHT;
      rotation_r <= 2'd0;
      mirror_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:    width_r    <= cfg_wr_data;
        CFG_HEIGHT:   height_r   <= cfg_wr_data;
        CFG_ROTATION: rotation_r <= cfg_wr_data[1:0];
        CFG_MIRROR:   mirror_r   <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_rnd = {width_r[DIM_W-1:3], 3'b000};
    if (width_rnd < DIM_W'(8)) begin
      wd = DIM_W'(8);
    end else if (width_rnd > DIM_W'(MAX_WIDTH)) begin
      wd = DIM_W'(MAX_WIDTH);
    end else begin
      wd = width_rnd;
    end
    if (height_r < DIM_W'(1)) begin
      ht = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      ht = DIM_W'(MAX_HEIGHT);
    end else begin
      ht = height_r;
    end
    geom.wd       = wd;
    geom.ht       = ht;
    geom.bpr      = wd[DIM_W-1:3];
    geom.size     = SIZE_W'(wd[DIM_W-1:3]) * SIZE_W'(ht);
    // 90 and 270 degrees swap the logical extents
    geom.xend     = rotation_r[0] ? ht : wd;
    geom.yend     = rotation_r[0] ? wd : ht;
    geom.rotation = rotation_r;
    geom.mirror   = mirror_r;
  end

endmodule

// ----- rtl/tfp_seq.sv -----
// Command sequencer: bounds check, rotation, row/byte stepping with read-modify-write,
// whole panel fill and byte read-back. Depends on tfp_pkg; drives the plane RAMs.
module tfp_seq
  import tfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  geom_t               geom,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [COLOR_W-1:0]  in_color,
  input  logic [POS_W-1:0]    in_pos_x,
  input  logic [POS_W-1:0]    in_pos_y,
  input  logic [DIM_W-1:0]    in_rect_w,
  input  logic [DIM_W-1:0]    in_rect_h,
  input  logic [ADDR_W-1:0]   in_read_address,
  output ram_req_t            ram_req,
  input  logic [7:0]          rd_black,
  input  logic [7:0]          rd_red,
  output logic                out_valid,
  output logic                out_status,
  output logic [7:0]          out_black_plane_byte,
  output logic [7:0]          out_red_plane_byte
);

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt;
  logic [7:0]          out_black_r, out_black_nxt;
  logic [7:0]          out_red_r, out_red_nxt;

  cmd_t                cmd_r, cmd_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic [POS_W-1:0]    px_r, px_nxt;
  logic [POS_W-1:0]    py_r, py_nxt;
  logic [DIM_W-1:0]    rw_r, rw_nxt;
  logic [DIM_W-1:0]    rh_r, rh_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;

  logic [DIM_W-1:0]    x0_r, x0_nxt;
  logic [DIM_W-1:0]    x1m1_r, x1m1_nxt;
  logic [DIM_W-1:0]    row_r, row_nxt;
  logic [DIM_W-1:0]    row_end_r, row_end_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [COL_W-1:0]    byte_r, byte_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   waddr_r, waddr_nxt;
  logic [7:0]          mask_r, mask_nxt;

  // setup arithmetic
  logic [DIM_W-1:0]    ew, eh;
  logic [EXT_W-1:0]    xsum, ysum;
  logic [DIM_W-1:0]    xs, ys;
  logic                oob, empty;
  logic [DIM_W-1:0]    tx, ty, tw, th;
  // stepping
  logic [DIM_W-1:0]    rphys;
  logic [COL_W-1:0]    first_col, last_col;
  logic                col_done, row_done;
  logic [ADDR_W-1:0]   byte_addr;
  logic [7:0]          mask;
  logic [7:0]          full_black, full_red;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_black_r  <= out_black_nxt;
    out_red_r    <= out_red_nxt;
    cmd_r        <= cmd_nxt;
    color_r      <= color_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    rw_r         <= rw_nxt;
    rh_r         <= rh_nxt;
    addr_r       <= addr_nxt;
    x0_r         <= x0_nxt;
    x1m1_r       <= x1m1_nxt;
    row_r        <= row_nxt;
    row_end_r    <= row_end_nxt;
    base_r       <= base_nxt;
    byte_r       <= byte_nxt;
    cnt_r        <= cnt_nxt;
    waddr_r      <= waddr_nxt;
    mask_r       <= mask_nxt;
  end

  // A point is a 1x1 rectangle: same bounds test and same rotation
  always_comb begin
    ew    = (cmd_r == CMD_POINT) ? DIM_W'(1) : rw_r;
    eh    = (cmd_r == CMD_POINT) ? DIM_W'(1) : rh_r;
    xsum  = EXT_W'(px_r) + EXT_W'(ew);
    ysum  = EXT_W'(py_r) + EXT_W'(eh);
    xs    = xsum[DIM_W-1:0];
    ys    = ysum[DIM_W-1:0];
    oob   = (xsum > EXT_W'(geom.xend)) || (ysum > EXT_W'(geom.yend));
    empty = (ew == DIM_W'(0)) || (eh == DIM_W'(0));
    case (geom.rotation)
      2'd1: begin
        tx = geom.wd - ys;
        ty = DIM_W'(px_r);
        tw = eh;
        th = ew;
      end
      2'd2: begin
        tx = geom.wd - xs;
        ty = geom.ht - ys;
        tw = ew;
        th = eh;
      end
      2'd3: begin
        tx = DIM_W'(py_r);
        ty = geom.ht - xs;
        tw = eh;
        th = ew;
      end
      default: begin
        tx = DIM_W'(px_r);
        ty = DIM_W'(py_r);
        tw = ew;
        th = eh;
      end
    endcase
  end

  always_comb begin
    rphys      = geom.mirror ? (geom.ht - DIM_W'(1) - row_r) : row_r;
    first_col  = x0_r[COL_W+2:3];
    last_col   = x1m1_r[COL_W+2:3];
    col_done   = (byte_r == last_col);
    row_done   = ((row_r + DIM_W'(1)) == row_end_r);
    byte_addr  = base_r + ADDR_W'(byte_r);
    mask       = span_mask(byte_r == first_col, col_done, x0_r[2:0], x1m1_r[2:0]);
    full_black = (color_r == COLOR_BLACK) ? BYTE_FULL : BYTE_EMPTY;
    full_red   = (color_r == COLOR_RED) ? BYTE_FULL : BYTE_EMPTY;
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_black_nxt  = out_black_r;
    out_red_nxt    = out_red_r;
    cmd_nxt        = cmd_r;
    color_nxt      = color_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    rw_nxt         = rw_r;
    rh_nxt         = rh_r;
    addr_nxt       = addr_r;
    x0_nxt         = x0_r;
    x1m1_nxt       = x1m1_r;
    row_nxt        = row_r;
    row_end_nxt    = row_end_r;
    base_nxt       = base_r;
    byte_nxt       = byte_r;
    cnt_nxt        = cnt_r;
    waddr_nxt      = waddr_r;
    mask_nxt       = mask_r;
    ram_req        = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_t'(in_command);
          color_nxt = in_color;
          px_nxt    = in_pos_x;
          py_nxt    = in_pos_y;
          rw_nxt    = in_rect_w;
          rh_nxt    = in_rect_h;
          addr_nxt  = in_read_address;
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        out_black_nxt = BYTE_EMPTY;
        out_red_nxt   = BYTE_EMPTY;
        case (cmd_r)
          CMD_FILL: begin
            cnt_nxt   = '0;
            state_nxt = ST_FILL;
          end
          CMD_READ: begin
            if (SIZE_W'(addr_r) >= geom.size) begin
              out_status_nxt = 1'b1;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = addr_r;
              state_nxt       = ST_RDWAIT;
            end
          end
          default: begin
            // point or rectangle; bounds are tested before emptiness
            if (oob || empty) begin
              out_status_nxt = oob;
              out_valid_nxt  = 1'b1;
              state_nxt      = ST_IDLE;
            end else begin
              x0_nxt      = tx;
              x1m1_nxt    = tx + tw - DIM_W'(1);
              row_nxt     = ty;
              row_end_nxt = ty + th;
              state_nxt   = ST_ROW;
            end
          end
        endcase
      end

      ST_ROW: begin
        base_nxt  = ADDR_W'(rphys) * ADDR_W'(geom.bpr);
        byte_nxt  = first_col;
        state_nxt = ST_BYTE;
      end

      ST_BYTE: begin
        if (mask == BYTE_FULL) begin
          // whole byte covered: no read needed
          ram_req.wr_en    = 1'b1;
          ram_req.wr_addr  = byte_addr;
          ram_req.wr_black = full_black;
          ram_req.wr_red   = full_red;
          if (!col_done) begin
            byte_nxt = byte_r + COL_W'(1);
          end else if (row_done) begin
            out_status_nxt = 1'b0;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            row_nxt   = row_r + DIM_W'(1);
            state_nxt = ST_ROW;
          end
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = byte_addr;
          waddr_nxt       = byte_addr;
          mask_nxt        = mask;
          state_nxt       = ST_MODIFY;
        end
      end

      ST_MODIFY: begin
        ram_req.wr_en    = 1'b1;
        ram_req.wr_addr  = waddr_r;
        ram_req.wr_black = paint(rd_black, mask_r, color_r == COLOR_BLACK);
        ram_req.wr_red   = paint(rd_red, mask_r, color_r == COLOR_RED);
        if (!col_done) begin
          byte_nxt  = byte_r + COL_W'(1);
          state_nxt = ST_BYTE;
        end else if (row_done) begin
          out_status_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          row_nxt   = row_r + DIM_W'(1);
          state_nxt = ST_ROW;
        end
      end

      ST_FILL: begin
        ram_req.wr_en    = 1'b1;
        ram_req.wr_addr  = cnt_r;
        ram_req.wr_black = full_black;
        ram_req.wr_red   = full_red;
        if ((SIZE_W'(cnt_r) + SIZE_W'(1)) == geom.size) begin
          out_status_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end

      ST_RDWAIT: begin
        out_status_nxt = 1'b0;
        out_black_nxt  = rd_black;
        out_red_nxt    = rd_red;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_black_plane_byte = out_black_r;
  assign out_red_plane_byte   = out_red_r;

  // every transaction ends in exactly one single-cycle strobe
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cmd_r != CMD_READ || out_status_r)) |->
      (out_black_r == BYTE_EMPTY && out_red_r == BYTE_EMPTY))
    else $error("plane bytes non-zero on a non-read or rejected result");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> (state_r == ST_BYTE || state_r == ST_MODIFY || state_r == ST_FILL))
    else $error("plane write outside a painting state");

  a_modify_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODIFY) |-> $past(ram_req.rd_en))
    else $error("read-modify-write without a preceding read");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != ST_SETUP) |=> state_r != ST_SETUP)
    else $error("new transaction started while busy");

endmodule

// ----- rtl/tricolor_framebuffer_painter_unit.sv -----
// Top level of the tricolor frame buffer painter: config registers, sequencer, plane RAMs.
// Depends on tfp_pkg, tfp_cfg, tfp_seq and tfp_ram.
//
//  channel | ports                                      | transaction
//  --------+--------------------------------------------+----------------------------------
//  config  | cfg_wr_en, cfg_index, cfg_wr_data          | write at any edge with cfg_wr_en
//  command | start, busy, in_*                          | edge with start high, busy low
//  result  | out_valid, out_status, out_*_plane_byte    | the single cycle out_valid is high
//
// One command at a time; busy is high from acceptance until the result strobe.
// Rejected or empty point/rectangle: strobe from setup. Read: setup, then a RAM read wait.
// Point or rectangle: per row a row state, then a write per fully covered byte, or a
// read and a modify write per edge byte. Whole panel fill: one plane byte per cycle through
// the RAM write port. No clearing pass after reset; plane contents are undefined until
// written. Reset is synchronous; results cannot be stalled by the receiver.
module tricolor_framebuffer_painter_unit
  import tfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [COLOR_W-1:0]   in_color,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [DIM_W-1:0]     in_rect_w,
  input  logic [DIM_W-1:0]     in_rect_h,
  input  logic [ADDR_W-1:0]    in_read_address,
  output logic                 out_valid,
  output logic                 out_status,
  output logic [7:0]           out_black_plane_byte,
  output logic [7:0]           out_red_plane_byte
);

  geom_t      geom;
  ram_req_t   ram_req;
  logic [7:0] rd_black;
  logic [7:0] rd_red;

  tfp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .geom        (geom)
  );

  tfp_seq u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .geom                 (geom),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_color             (in_color),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_rect_w            (in_rect_w),
    .in_rect_h            (in_rect_h),
    .in_read_address      (in_read_address),
    .ram_req              (ram_req),
    .rd_black             (rd_black),
    .rd_red               (rd_red),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_black_plane_byte (out_black_plane_byte),
    .out_red_plane_byte   (out_red_plane_byte)
  );

  tfp_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_DEPTH)
  ) u_black_plane (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_black),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_black)
  );

  tfp_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_DEPTH)
  ) u_red_plane (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_red),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_red)
  );

endmodule
